@@ hdl/dmfs_pkg.sv @@
// Shared constants, types and helpers of the dot-matrix frame buffer scanout block.
`default_nettype none

package dmfs_pkg;

  // Grid geometry
  localparam int MODULE_ROWS   = 1;
  localparam int MODULE_COLS   = 4;
  localparam int DOTS_PER_SIDE = 8;
  localparam int MODULE_COUNT  = MODULE_ROWS * MODULE_COLS;
  localparam int FRAME_BYTES   = DOTS_PER_SIDE * MODULE_COUNT;
  localparam int ADDR_W        = $clog2(FRAME_BYTES);
  localparam int MOD_W         = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

  localparam logic [7:0] LEFT_DOT_MASK = 8'b10000000;
  localparam logic [7:0] FULL_BYTE     = 8'b11111111;

  // Request type codes on the input channel
  localparam logic [2:0] REQ_SET     = 3'd0;
  localparam logic [2:0] REQ_CLEAR   = 3'd1;
  localparam logic [2:0] REQ_TOGGLE  = 3'd2;
  localparam logic [2:0] REQ_READ    = 3'd3;
  localparam logic [2:0] REQ_ALL_ON  = 3'd4;
  localparam logic [2:0] REQ_ALL_OFF = 3'd5;
  localparam logic [2:0] REQ_REFRESH = 3'd6;

  // Resolved operation handed from front to back
  typedef enum logic [2:0] {
    OP_LIGHT,
    OP_DARK,
    OP_TOGGLE,
    OP_READ,
    OP_ALL_ON,
    OP_ALL_OFF,
    OP_REFRESH,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        mask;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic       read_value;
    logic [3:0] digit_addr;
    logic [7:0] seg_data;
    logic       latch_after;
    logic       last;
  } res_t;

  function automatic logic [7:0] bit_reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7-k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/dmfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/dmfs_front.sv @@
// Front end: accepts requests, classifies them and queues resolved commands.
`default_nettype none

module dmfs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               draw_set_mode_i,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [7:0]  x_coord_i,
  input  wire logic signed [7:0]  y_coord_i,
  output logic                    cmd_valid_o,
  output dmfs_pkg::cmd_t          cmd_o,
  input  wire logic               cmd_pop_i
);

  localparam int XLim = dmfs_pkg::MODULE_COLS * dmfs_pkg::DOTS_PER_SIDE;
  localparam int YLim = dmfs_pkg::MODULE_ROWS * dmfs_pkg::DOTS_PER_SIDE;

  dmfs_pkg::cmd_t cmd_new;
  logic           in_grid;
  logic           wr_en;

  dmfs_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  always_comb begin
    in_grid = !x_coord_i[7] && (x_coord_i[6:0] < 7'(XLim)) &&
              !y_coord_i[7] && (y_coord_i[6:0] < 7'(YLim));
    cmd_new.idx  = dmfs_pkg::ADDR_W'(
                     (32'(y_coord_i[6:3]) * dmfs_pkg::MODULE_COLS + 32'(x_coord_i[6:3]))
                     * dmfs_pkg::DOTS_PER_SIDE + 32'(y_coord_i[2:0]));
    cmd_new.mask = dmfs_pkg::LEFT_DOT_MASK >> x_coord_i[2:0];
    unique case (req_type_i)
      dmfs_pkg::REQ_SET: begin
        cmd_new.op = !in_grid ? dmfs_pkg::OP_REJECT :
                     (draw_set_mode_i ? dmfs_pkg::OP_LIGHT : dmfs_pkg::OP_DARK);
      end
      dmfs_pkg::REQ_CLEAR: begin
        cmd_new.op = !in_grid ? dmfs_pkg::OP_REJECT :
                     (draw_set_mode_i ? dmfs_pkg::OP_DARK : dmfs_pkg::OP_LIGHT);
      end
      dmfs_pkg::REQ_TOGGLE: begin
        cmd_new.op = in_grid ? dmfs_pkg::OP_TOGGLE : dmfs_pkg::OP_REJECT;
      end
      dmfs_pkg::REQ_READ: begin
        cmd_new.op = in_grid ? dmfs_pkg::OP_READ : dmfs_pkg::OP_REJECT;
      end
      dmfs_pkg::REQ_ALL_ON:  cmd_new.op = dmfs_pkg::OP_ALL_ON;
      dmfs_pkg::REQ_ALL_OFF: cmd_new.op = dmfs_pkg::OP_ALL_OFF;
      dmfs_pkg::REQ_REFRESH: cmd_new.op = dmfs_pkg::OP_REFRESH;
      default:               cmd_new.op = dmfs_pkg::OP_REJECT;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign wr_en       = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(wr_en) - 2'(cmd_pop_i);
    end
  end

endmodule

`default_nettype wire

@@ hdl/dmfs_res_queue.sv @@
// Two-entry result queue between the back end and the result ports.
`default_nettype none

module dmfs_res_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dmfs_pkg::res_t data_i,
  output logic                full_o,
  output logic                empty_o,
  output dmfs_pkg::res_t      head_o,
  input  wire logic           pop_i
);

  dmfs_pkg::res_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

`default_nettype wire

@@ hdl/dmfs_back.sv @@
// Back end: executes queued commands against the frame store and scans out refresh words.
`default_nettype none

module dmfs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rotate_half_turn_i,
  input  wire logic           cmd_valid_i,
  input  wire dmfs_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output dmfs_pkg::res_t      res_o
);

  localparam int                   AW      = dmfs_pkg::ADDR_W;
  localparam int                   MW      = dmfs_pkg::MOD_W;
  localparam logic [MW-1:0]        LastCol = MW'(dmfs_pkg::MODULE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX,
    ST_SCAN
  } state_e;

  state_e                       state_q;
  dmfs_pkg::cmd_t               cmd_q;
  logic                         vld_rd_q;
  logic [dmfs_pkg::FRAME_BYTES-1:0] valid_q;
  logic                         fill_q;
  logic [2:0]                   row_q;
  logic [MW-1:0]                col_q;
  logic                         issue_done_q;
  logic                         pend_q;
  logic [3:0]                   p_dig_q;
  logic                         p_end_row_q;
  logic                         p_end_all_q;

  logic          re, we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata, eff, new_byte;
  logic [MW-1:0] scan_mod;
  logic          space, pix_issue, scan_issue, scan_emit;

  dmfs_ram #(
    .Width(8),
    .Depth(dmfs_pkg::FRAME_BYTES)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cmd_q.idx),
    .wdata_i(new_byte),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // An entry never written since the last fill reads as the fill value
  assign eff   = vld_rd_q ? rdata : {8{fill_q}};
  assign space = !res_full_i;

  always_comb begin
    scan_mod   = rotate_half_turn_i ? col_q : LastCol - col_q;
    scan_issue = (state_q == ST_SCAN) && !issue_done_q && (!pend_q || (pend_q && space));
    scan_emit  = (state_q == ST_SCAN) && pend_q && space;
    pix_issue  = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    we         = 1'b0;
    res_o      = '{ok: 1'b1, read_value: 1'b0, digit_addr: 4'd0, seg_data: 8'd0,
                   latch_after: 1'b0, last: 1'b1};

    unique case (cmd_q.op)
      dmfs_pkg::OP_LIGHT:  new_byte = eff | cmd_q.mask;
      dmfs_pkg::OP_DARK:   new_byte = eff & ~cmd_q.mask;
      dmfs_pkg::OP_TOGGLE: new_byte = eff ^ cmd_q.mask;
      default:             new_byte = eff;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            dmfs_pkg::OP_LIGHT, dmfs_pkg::OP_DARK,
            dmfs_pkg::OP_TOGGLE, dmfs_pkg::OP_READ: begin
              pix_issue = 1'b1;
              cmd_pop_o = 1'b1;
            end
            dmfs_pkg::OP_ALL_ON, dmfs_pkg::OP_ALL_OFF: begin
              cmd_pop_o  = space;
              res_push_o = space;
            end
            dmfs_pkg::OP_REJECT: begin
              cmd_pop_o  = space;
              res_push_o = space;
              res_o.ok   = 1'b0;
            end
            dmfs_pkg::OP_REFRESH: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_PIX: begin
        res_push_o       = space;
        we               = space && (cmd_q.op != dmfs_pkg::OP_READ);
        res_o.read_value = (cmd_q.op == dmfs_pkg::OP_READ) && ((eff & cmd_q.mask) != 8'd0);
      end
      ST_SCAN: begin
        res_push_o        = scan_emit;
        res_o.digit_addr  = p_dig_q;
        res_o.seg_data    = rotate_half_turn_i ? eff : dmfs_pkg::bit_reverse8(eff);
        res_o.latch_after = p_end_row_q;
        res_o.last        = p_end_all_q;
      end
      default: begin
        res_push_o = 1'b0;
      end
    endcase

    re    = pix_issue || scan_issue;
    raddr = pix_issue ? cmd_i.idx : AW'({scan_mod, row_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= '{op: dmfs_pkg::OP_REJECT, idx: '0, mask: '0};
      vld_rd_q     <= 1'b0;
      valid_q      <= '0;
      fill_q       <= 1'b0;
      row_q        <= 3'd0;
      col_q        <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      p_dig_q      <= 4'd0;
      p_end_row_q  <= 1'b0;
      p_end_all_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pix_issue) begin
            cmd_q    <= cmd_i;
            vld_rd_q <= valid_q[cmd_i.idx];
            state_q  <= ST_PIX;
          end else if (cmd_pop_o && (cmd_i.op == dmfs_pkg::OP_REFRESH)) begin
            row_q        <= 3'd0;
            col_q        <= '0;
            issue_done_q <= 1'b0;
            pend_q       <= 1'b0;
            state_q      <= ST_SCAN;
          end else if (cmd_pop_o && (cmd_i.op == dmfs_pkg::OP_ALL_ON ||
                                     cmd_i.op == dmfs_pkg::OP_ALL_OFF)) begin
            valid_q <= '0;
            fill_q  <= (cmd_i.op == dmfs_pkg::OP_ALL_ON);
          end
        end
        ST_PIX: begin
          if (space) begin
            if (we) begin
              valid_q[cmd_q.idx] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            vld_rd_q    <= valid_q[AW'({scan_mod, row_q})];
            p_dig_q     <= rotate_half_turn_i ? 4'(row_q) + 4'd1 : 4'd8 - 4'(row_q);
            p_end_row_q <= (col_q == LastCol);
            p_end_all_q <= (col_q == LastCol) && (row_q == 3'd7);
            if (col_q == LastCol) begin
              col_q <= '0;
              if (row_q == 3'd7) begin
                issue_done_q <= 1'b1;
              end else begin
                row_q <= row_q + 3'd1;
              end
            end else begin
              col_q <= col_q + MW'(1);
            end
          end
          if (scan_issue) begin
            pend_q <= 1'b1;
          end else if (scan_emit) begin
            pend_q <= 1'b0;
          end
          if (scan_emit && p_end_all_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/dot_matrix_framebuffer_scanout_core.sv @@
// Top level of the dot-matrix frame buffer with refresh scanout.
//
//  Channel   Direction  Handshake               Beat contents
//  --------  ---------  ----------------------  ------------------------------------------
//  request   in         push / full             req_type, x_coord, y_coord
//  result    out        empty / pop             ok, read_value, digit_addr, seg_data,
//                                               latch_after, last
//  config    in         psel/penable/pwrite     draw_set_mode @0x0, rotate_half_turn @0x4
//
// A set, clear, toggle or read first reads the frame byte from the store's registered port,
// then merges it and writes it back, or for a read tests the bit; this waits for result space.
// All on, all off and rejected requests finish at dispatch without touching the store; for all
// on and all off a fill flag and per-byte valid bits stand in for sweeping the store. Refresh is
// dispatched, then emits 8*MODULE_COUNT beats at one per cycle while the result queue has room,
// paced by the store's one read port.
// Reset clears the queues and valid bits and resets the registers; no clearing pass is needed.
// A full result queue stalls only the back end; the request queue keeps taking beats
// until its two entries fill.
`default_nettype none

module dot_matrix_framebuffer_scanout_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        req_type_i,
  input  wire logic signed [7:0] x_coord_i,
  input  wire logic signed [7:0] y_coord_i,
  // result channel
  output logic                   empty,
  input  wire logic              pop,
  output logic                   ok_o,
  output logic                   read_value_o,
  output logic [3:0]             digit_addr_o,
  output logic [7:0]             seg_data_o,
  output logic                   latch_after_o,
  output logic                   last_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Register select is address bit 2; the low bits are byte lanes
  localparam logic RegDrawMode = 1'b0;

  logic           draw_set_mode_q;
  logic           rotate_half_turn_q;
  logic           cfg_wr;

  logic           cmd_valid, cmd_pop;
  dmfs_pkg::cmd_t cmd;
  logic           res_push, res_full;
  dmfs_pkg::res_t res_new, res_head;

  // Configuration: every access completes at once
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegDrawMode) ? 32'(draw_set_mode_q) : 32'(rotate_half_turn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_set_mode_q    <= 1'b1;
      rotate_half_turn_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegDrawMode) begin
        draw_set_mode_q <= pwdata[0];
      end else begin
        rotate_half_turn_q <= pwdata[0];
      end
    end
  end

  // Front end: classify the request and hold it until the back end takes it
  dmfs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .draw_set_mode_i(draw_set_mode_q),
    .push_i         (push),
    .full_o         (full),
    .req_type_i     (req_type_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // Back end: read-modify-write of frame bytes and refresh scanout
  dmfs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rotate_half_turn_i(rotate_half_turn_q),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .res_full_i        (res_full),
    .res_push_o        (res_push),
    .res_o             (res_new)
  );

  // Result queue decouples the back end from the consumer
  dmfs_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_new),
    .full_o (res_full),
    .empty_o(empty),
    .head_o (res_head),
    .pop_i  (pop)
  );

  assign ok_o          = res_head.ok;
  assign read_value_o  = res_head.read_value;
  assign digit_addr_o  = res_head.digit_addr;
  assign seg_data_o    = res_head.seg_data;
  assign latch_after_o = res_head.latch_after;
  assign last_o        = res_head.last;

endmodule

`default_nettype wire
